FILE: rtl/temperature_band_monitor_macros.svh
// Assertion macros shared by the temperature band monitor RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef TEMPERATURE_BAND_MONITOR_MACROS_SVH
`define TEMPERATURE_BAND_MONITOR_MACROS_SVH

// Check a condition at every clock edge out of reset
`define TBM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define TBM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/tbm_pkg.sv
// Shared types, codes and constants of the temperature band monitor.
// No dependencies; used by every module of the block.
`default_nettype none

package tbm_pkg;

  // Field widths of the words
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned THR_W    = 14;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  // Widest running sum that the conversion datapath supports
  localparam int unsigned SUM_MAX_W = 40;

  // Commands
  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_EVALUATE   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TRIP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RELEASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RELEASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TRIP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT  = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0]        GAIN_RST         = 24'd75945;
  localparam logic signed [TEMP_W-1:0] OFFSET_RST       = -16'sd1879;
  localparam logic [THR_W-1:0]         LOW_TRIP_RST     = 14'd1900;
  localparam logic [THR_W-1:0]         LOW_RELEASE_RST  = 14'd2000;
  localparam logic [THR_W-1:0]         HIGH_RELEASE_RST = 14'd2500;
  localparam logic [THR_W-1:0]         HIGH_TRIP_RST    = 14'd2600;
  localparam logic [THR_W-1:0]         FAULT_LIMIT_RST  = 14'd7000;

  // Band codes as reported
  localparam logic [1:0] BAND_CODE_NORMAL = 2'd0;
  localparam logic [1:0] BAND_CODE_LOW    = 2'd1;
  localparam logic [1:0] BAND_CODE_HIGH   = 2'd2;
  localparam logic [1:0] BAND_CODE_FAULT  = 2'd3;

  // Fault kinds
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_OPEN     = 2'd1;
  localparam logic [1:0] FAULT_SHORT    = 2'd2;
  localparam logic [1:0] FAULT_BOUNDARY = 2'd3;

  // Temperature limits
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 16'sd32767;
  localparam logic [THR_W-1:0]         CLAMP_MAX = 14'd9999;

  // Reciprocal multipliers for the decimal split (exact over the used ranges)
  localparam logic [13:0] DIV1000_MUL = 14'd8389;  // c < 10000, shift 23
  localparam logic [5:0]  DIV100_MUL  = 6'd41;     // r < 1000,  shift 12
  localparam logic [7:0]  DIV10_MUL   = 8'd205;    // r < 100,   shift 11

  // Band state, one-hot
  typedef enum logic [3:0] {
    BAND_NORMAL = 4'b0001,
    BAND_LOW    = 4'b0010,
    BAND_HIGH   = 4'b0100,
    BAND_FAULT  = 4'b1000
  } tbm_band_t;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
  } tbm_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [1:0]               band;
    logic [1:0]               fault_kind;
    logic [3:0]               digit_thousands;
    logic [3:0]               digit_hundreds;
    logic [3:0]               digit_tens;
    logic [3:0]               digit_units;
  } tbm_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        gain;
    logic signed [TEMP_W-1:0] offset;
    logic [THR_W-1:0]         low_trip;
    logic [THR_W-1:0]         low_release;
    logic [THR_W-1:0]         high_release;
    logic [THR_W-1:0]         high_trip;
    logic [THR_W-1:0]         fault_limit;
  } tbm_cfg_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } tbm_qstat_t;

  // Map the one-hot band state to its reported code
  function automatic logic [1:0] band_code(tbm_band_t b);
    logic [1:0] code;
    case (b)
      BAND_NORMAL: code = BAND_CODE_NORMAL;
      BAND_LOW:    code = BAND_CODE_LOW;
      BAND_HIGH:   code = BAND_CODE_HIGH;
      default:     code = BAND_CODE_FAULT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tbm_front.sv
// Front part: accepts words, accumulates samples and issues evaluate jobs.
// Depends on tbm_pkg and temperature_band_monitor_macros.svh.
`default_nettype none
`include "temperature_band_monitor_macros.svh"

module tbm_front #(
  parameter int unsigned SUM_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tbm_pkg::tbm_in_t      in_data,
  input  wire tbm_pkg::tbm_qstat_t   qstat,
  output logic                       push,
  output logic [SUM_BITS-1:0]        push_sum
);

  logic [SUM_BITS-1:0] sum_r;
  logic [SUM_BITS-1:0] sum_nxt;
  logic [SUM_BITS:0]   sum_add;
  logic                in_fire;

  // Stall only when the job queue has no room
  assign in_stall = qstat.full;
  assign in_fire  = in_valid && !in_stall;
  assign push     = in_fire && (in_data.command == tbm_pkg::CMD_EVALUATE);
  assign push_sum = sum_r;

  // Add the sample with carry, hold at the maximum on overflow
  assign sum_add = {1'b0, sum_r} + (SUM_BITS+1)'(in_data.sample);

  always_comb begin
    sum_nxt = sum_r;
    if (in_fire) begin
      if (in_data.command == tbm_pkg::CMD_EVALUATE) begin
        sum_nxt = '0;
      end else if (sum_add[SUM_BITS]) begin
        sum_nxt = '1;
      end else begin
        sum_nxt = sum_add[SUM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  `TBM_ASSERT_NEXT(a_sum_cleared, push, sum_r == '0, "running sum not cleared after evaluate")
  `TBM_ASSERT(a_no_push_full, !(push && qstat.full), "evaluate issued into a full queue")
  `TBM_ASSERT_NEXT(a_sum_no_wrap, in_fire && in_data.command == tbm_pkg::CMD_ACCUMULATE, sum_r >= $past(sum_r), "running sum wrapped")

endmodule

`default_nettype wire

FILE: rtl/tbm_queue.sv
// Two-entry job queue between the front and back parts.
// Depends on tbm_pkg and temperature_band_monitor_macros.svh.
`default_nettype none
`include "temperature_band_monitor_macros.svh"

module tbm_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [WIDTH-1:0]    push_data,
  input  wire logic                pop,
  output logic [WIDTH-1:0]         head_data,
  output tbm_pkg::tbm_qstat_t      qstat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign qstat.full  = (count_r == 2'd2);
  assign qstat.empty = (count_r == 2'd0);
  assign head_data   = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TBM_ASSERT(a_no_pop_empty, !(pop && qstat.empty), "pop from empty queue")
  `TBM_ASSERT(a_count_range, count_r != 2'd3, "queue count out of range")
  `TBM_ASSERT(a_ptr_count, (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "queue pointers disagree with count")

endmodule

`default_nettype wire

FILE: rtl/tbm_back.sv
// Back part: converts a latched sum to temperature, updates the band and
// splits the digits in a stalling pipeline. Depends on tbm_pkg and the macros.
`default_nettype none
`include "temperature_band_monitor_macros.svh"

module tbm_back #(
  parameter int unsigned SUM_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tbm_pkg::tbm_cfg_t    cfg,
  input  wire tbm_pkg::tbm_qstat_t  qstat,
  input  wire logic [SUM_BITS-1:0]  head_sum,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tbm_pkg::tbm_out_t         out_data
);

  localparam int unsigned SW = tbm_pkg::SUM_MAX_W;
  localparam int unsigned TW = tbm_pkg::TEMP_W;

  logic advance;

  // Stage 1: partial products
  logic          s1_v_r;
  logic [39:0]   s1_hi_r;
  logic [47:0]   s1_lo_r;
  logic [SW-1:0] sum_ext;

  // Stage 2: temperature
  logic                     s2_v_r;
  logic signed [TW-1:0]     s2_t_r;
  logic [40:0]              quot;
  logic signed [18:0]       t_wide;
  logic signed [TW-1:0]     t_sat;

  // Stage 3: band, fault kind, clamp
  logic                     s3_v_r;
  logic signed [TW-1:0]     s3_t_r;
  logic [1:0]               s3_band_r;
  logic [1:0]               s3_kind_r;
  logic [13:0]              s3_c_r;
  tbm_pkg::tbm_band_t       band_r;
  tbm_pkg::tbm_band_t       band_nxt;
  logic [1:0]               kind;
  logic [13:0]              clamp;

  // Stage 4: thousands
  logic                     s4_v_r;
  logic signed [TW-1:0]     s4_t_r;
  logic [1:0]               s4_band_r;
  logic [1:0]               s4_kind_r;
  logic [3:0]               s4_th_r;
  logic [9:0]               s4_rem_r;
  logic [27:0]              th_prod;
  logic [3:0]               th;
  logic [13:0]              rem1;

  // Stage 5: hundreds
  logic                     s5_v_r;
  logic signed [TW-1:0]     s5_t_r;
  logic [1:0]               s5_band_r;
  logic [1:0]               s5_kind_r;
  logic [3:0]               s5_th_r;
  logic [3:0]               s5_hu_r;
  logic [6:0]               s5_rem_r;
  logic [15:0]              hu_prod;
  logic [3:0]               hu;
  logic [9:0]               rem2;

  // Output register: tens and units
  logic                     out_v_r;
  tbm_pkg::tbm_out_t        out_r;
  logic [14:0]              tn_prod;
  logic [3:0]               tn;
  logic [6:0]               un;

  logic signed [TW-1:0] low_trip_s;
  logic signed [TW-1:0] low_rel_s;
  logic signed [TW-1:0] high_rel_s;
  logic signed [TW-1:0] high_trip_s;
  logic signed [TW-1:0] limit_s;

  // Move the whole pipeline unless the output word is held
  assign advance   = !out_v_r || !out_stall;
  assign pop       = advance && !qstat.empty;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Stage 1: split the sum and multiply both halves by the gain
  assign sum_ext = SW'(head_sum);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_hi_r <= 40'(sum_ext[SW-1:24]) * 40'(cfg.gain);
      s1_lo_r <= 48'(sum_ext[23:0]) * 48'(cfg.gain);
    end
  end

  // Stage 2: combine, add the offset, saturate to 16 bits
  always_comb begin
    quot   = 41'(s1_hi_r) + 41'(s1_lo_r[47:24]);
    t_wide = $signed({2'b00, quot[16:0]}) + 19'(cfg.offset);
    if ((|quot[40:17]) || (t_wide > 19'sd32767)) begin
      t_sat = tbm_pkg::TEMP_MAX;
    end else begin
      t_sat = t_wide[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_t_r <= t_sat;
    end
  end

  // Stage 3: band update with hysteresis
  assign low_trip_s  = $signed({2'b00, cfg.low_trip});
  assign low_rel_s   = $signed({2'b00, cfg.low_release});
  assign high_rel_s  = $signed({2'b00, cfg.high_release});
  assign high_trip_s = $signed({2'b00, cfg.high_trip});
  assign limit_s     = $signed({2'b00, cfg.fault_limit});

  always_comb begin
    band_nxt = band_r;
    if (s2_t_r < 0 || s2_t_r > limit_s) begin
      band_nxt = tbm_pkg::BAND_FAULT;
    end else begin
      case (band_r)
        tbm_pkg::BAND_NORMAL: begin
          if (s2_t_r < low_trip_s) begin
            band_nxt = tbm_pkg::BAND_LOW;
          end else if (s2_t_r > high_trip_s) begin
            band_nxt = tbm_pkg::BAND_HIGH;
          end else begin
            band_nxt = tbm_pkg::BAND_NORMAL;
          end
        end
        tbm_pkg::BAND_LOW: begin
          band_nxt = (s2_t_r > low_rel_s) ? tbm_pkg::BAND_NORMAL : tbm_pkg::BAND_LOW;
        end
        tbm_pkg::BAND_HIGH: begin
          band_nxt = (s2_t_r < high_rel_s) ? tbm_pkg::BAND_NORMAL : tbm_pkg::BAND_HIGH;
        end
        default: begin
          if (s2_t_r > low_trip_s && s2_t_r < high_trip_s) begin
            band_nxt = tbm_pkg::BAND_NORMAL;
          end else if (s2_t_r < low_trip_s) begin
            band_nxt = tbm_pkg::BAND_LOW;
          end else if (s2_t_r > high_trip_s) begin
            band_nxt = tbm_pkg::BAND_HIGH;
          end else begin
            band_nxt = tbm_pkg::BAND_FAULT;
          end
        end
      endcase
    end
  end

  // Classify the fault and clamp for the display digits
  always_comb begin
    kind = tbm_pkg::FAULT_NONE;
    if (band_nxt == tbm_pkg::BAND_FAULT) begin
      if (s2_t_r > limit_s) begin
        kind = tbm_pkg::FAULT_SHORT;
      end else if (s2_t_r < 0) begin
        kind = tbm_pkg::FAULT_OPEN;
      end else begin
        kind = tbm_pkg::FAULT_BOUNDARY;
      end
    end
    if (s2_t_r < 0) begin
      clamp = '0;
    end else if (s2_t_r > $signed({2'b00, tbm_pkg::CLAMP_MAX})) begin
      clamp = tbm_pkg::CLAMP_MAX;
    end else begin
      clamp = s2_t_r[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= tbm_pkg::BAND_FAULT;
    end else if (advance && s2_v_r) begin
      band_r <= band_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_t_r    <= s2_t_r;
      s3_band_r <= tbm_pkg::band_code(band_nxt);
      s3_kind_r <= kind;
      s3_c_r    <= clamp;
    end
  end

  // Stage 4: thousands digit by reciprocal, remainder by shift-add
  always_comb begin
    th_prod = 28'(s3_c_r) * 28'(tbm_pkg::DIV1000_MUL);
    th      = th_prod[26:23];
    rem1    = s3_c_r - (14'({th, 10'b0}) - 14'({th, 4'b0}) - 14'({th, 3'b0}));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_t_r    <= s3_t_r;
      s4_band_r <= s3_band_r;
      s4_kind_r <= s3_kind_r;
      s4_th_r   <= th;
      s4_rem_r  <= rem1[9:0];
    end
  end

  // Stage 5: hundreds digit
  always_comb begin
    hu_prod = 16'(s4_rem_r) * 16'(tbm_pkg::DIV100_MUL);
    hu      = hu_prod[15:12];
    rem2    = s4_rem_r - (10'({hu, 6'b0}) + 10'({hu, 5'b0}) + 10'({hu, 2'b0}));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_t_r    <= s4_t_r;
      s5_band_r <= s4_band_r;
      s5_kind_r <= s4_kind_r;
      s5_th_r   <= s4_th_r;
      s5_hu_r   <= hu;
      s5_rem_r  <= rem2[6:0];
    end
  end

  // Output stage: tens and units
  always_comb begin
    tn_prod = 15'(s5_rem_r) * 15'(tbm_pkg::DIV10_MUL);
    tn      = tn_prod[14:11];
    un      = s5_rem_r - (7'({tn, 3'b0}) + 7'({tn, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.temperature     <= s5_t_r;
      out_r.band            <= s5_band_r;
      out_r.fault_kind      <= s5_kind_r;
      out_r.digit_thousands <= s5_th_r;
      out_r.digit_hundreds  <= s5_hu_r;
      out_r.digit_tens      <= tn;
      out_r.digit_units     <= un[3:0];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= !qstat.empty;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      out_v_r <= s5_v_r;
    end
  end

  `TBM_ASSERT(a_kind_band, !out_v_r || ((out_r.fault_kind == tbm_pkg::FAULT_NONE) == (out_r.band != tbm_pkg::BAND_CODE_FAULT)), "fault kind disagrees with band")
  `TBM_ASSERT(a_digits, !out_v_r || (out_r.digit_thousands <= 4'd9 && out_r.digit_hundreds <= 4'd9 && out_r.digit_tens <= 4'd9 && out_r.digit_units <= 4'd9), "decimal digit out of range")
  `TBM_ASSERT_NEXT(a_band_hold, !(advance && s2_v_r), $stable(band_r), "band changed without an evaluate")

endmodule

`default_nettype wire

FILE: rtl/temperature_band_monitor.sv
// Temperature band monitor: accumulates converter samples, then converts,
// classifies with hysteresis and splits digits. Takes one word per cycle
// unless the job queue is full; an evaluate word passes the job queue, then
// the multiply, offset, band and three digit stages of the back pipeline.
// Synchronous reset clears the sum, sets the band to fault and loads register defaults.
`default_nettype none

module temperature_band_monitor #(
  parameter int unsigned SUM_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire tbm_pkg::tbm_in_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output tbm_pkg::tbm_out_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [tbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tbm_pkg::CFG_W-1:0]           cfg_data
);

  tbm_pkg::tbm_cfg_t   cfg_r;
  tbm_pkg::tbm_cfg_t   cfg_nxt;
  tbm_pkg::tbm_qstat_t qstat;
  logic                push;
  logic                pop;
  logic [SUM_BITS-1:0] push_sum;
  logic [SUM_BITS-1:0] head_sum;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tbm_pkg::CFG_GAIN:         cfg_nxt.gain         = cfg_data;
        tbm_pkg::CFG_OFFSET:       cfg_nxt.offset       = $signed(cfg_data[15:0]);
        tbm_pkg::CFG_LOW_TRIP:     cfg_nxt.low_trip     = cfg_data[13:0];
        tbm_pkg::CFG_LOW_RELEASE:  cfg_nxt.low_release  = cfg_data[13:0];
        tbm_pkg::CFG_HIGH_RELEASE: cfg_nxt.high_release = cfg_data[13:0];
        tbm_pkg::CFG_HIGH_TRIP:    cfg_nxt.high_trip    = cfg_data[13:0];
        tbm_pkg::CFG_FAULT_LIMIT:  cfg_nxt.fault_limit  = cfg_data[13:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain         <= tbm_pkg::GAIN_RST;
      cfg_r.offset       <= tbm_pkg::OFFSET_RST;
      cfg_r.low_trip     <= tbm_pkg::LOW_TRIP_RST;
      cfg_r.low_release  <= tbm_pkg::LOW_RELEASE_RST;
      cfg_r.high_release <= tbm_pkg::HIGH_RELEASE_RST;
      cfg_r.high_trip    <= tbm_pkg::HIGH_TRIP_RST;
      cfg_r.fault_limit  <= tbm_pkg::FAULT_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accumulate and issue evaluate jobs
  tbm_front #(
    .SUM_BITS(SUM_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .push_sum (push_sum)
  );

  // Job queue
  tbm_queue #(
    .WIDTH(SUM_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_sum),
    .pop       (pop),
    .head_data (head_sum),
    .qstat     (qstat)
  );

  // Back: conversion, band and digits
  tbm_back #(
    .SUM_BITS(SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .qstat     (qstat),
    .head_sum  (head_sum),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
